[rtl/bwmc_pkg.sv]
// Shared types, constants and single-precision float helpers for the bone world matrix chain.
package bwmc_pkg;

    localparam int MAX_BONES_DEF = 256;
    localparam int MAT_W         = 512;
    localparam int ROW_W         = 128;
    localparam int IN_DATA_W     = 280;
    localparam int OUT_DATA_W    = 144;
    localparam logic [1:0] ROW_LAST = 2'd3;

    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

    typedef struct packed {
        logic [7:0]       bone;
        logic [8:0]       parent;
        logic [MAT_W-1:0] rest;
        logic [MAT_W-1:0] basis;
    } job_t;

    function automatic logic [5:0] lzc49(input logic [48:0] r);
        logic [5:0] n;
        logic       found;
        n     = 6'd0;
        found = 1'b0;
        for (int i = 48; i >= 0; i--) begin
            if (!found && r[i]) begin
                n     = 6'(48 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] be,
                                               input logic [48:0] m);
        logic [11:0] sh;
        logic [48:0] sm;
        logic [48:0] mask;
        logic        lost;
        logic        g;
        logic        st;
        logic        inc;
        logic [30:0] base;
        logic [31:0] res;
        sh   = 12'd0;
        sm   = 49'd0;
        mask = 49'd0;
        lost = 1'b0;
        g    = 1'b0;
        st   = 1'b0;
        base = 31'd0;
        res  = 32'd0;
        if (be >= 12'sd255) begin
            res = {sign, 8'hFF, 23'd0};
        end
        else begin
            if (be >= 12'sd1) begin
                base = {be[7:0], m[47:25]};
                g    = m[24];
                st   = |m[23:0];
            end
            else begin
                sh = 12'(12'sd1 - be);
                if (sh >= 12'd49) begin
                    sm   = 49'd0;
                    lost = |m;
                end
                else begin
                    sm   = m >> sh;
                    mask = (49'd1 << sh) - 49'd1;
                    lost = |(m & mask);
                end
                base = {8'd0, sm[47:25]};
                g    = sm[24];
                st   = (|sm[23:0]) | lost;
            end
            inc = g & (st | base[0]);
            res = {sign, base + {30'd0, inc}};
        end
        return res;
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic               sr;
        logic               a_nan;
        logic               b_nan;
        logic               a_inf;
        logic               b_inf;
        logic               a_zero;
        logic               b_zero;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic signed [11:0] ea;
        logic signed [11:0] eb;
        logic signed [11:0] be;
        logic [47:0]        p;
        logic [48:0]        r;
        logic [5:0]         lz;
        logic [31:0]        res;
        sr     = a[31] ^ b[31];
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        ea     = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
        eb     = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
        p      = 48'(ma) * 48'(mb);
        r      = {p, 1'b0};
        lz     = lzc49(r);
        be     = ea + eb - 12'sd126 - $signed({6'd0, lz});
        priority if (a_nan) begin
            res = a | QUIET_BIT;
        end
        else if (b_nan) begin
            res = b | QUIET_BIT;
        end
        else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            res = DEFAULT_NAN;
        end
        else if (a_inf || b_inf) begin
            res = {sr, 8'hFF, 23'd0};
        end
        else if (a_zero || b_zero) begin
            res = {sr, 31'd0};
        end
        else begin
            res = round_pack(sr, be, r << lz);
        end
        return res;
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic               a_nan;
        logic               b_nan;
        logic               a_inf;
        logic               b_inf;
        logic [31:0]        x;
        logic [31:0]        y;
        logic signed [11:0] ex;
        logic [7:0]         ey;
        logic [7:0]         exu;
        logic [7:0]         d;
        logic [48:0]        xw;
        logic [48:0]        yw;
        logic [48:0]        ys;
        logic [48:0]        mask;
        logic               lost;
        logic [48:0]        r;
        logic [5:0]         lz;
        logic signed [11:0] be;
        logic [31:0]        res;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end
        else begin
            x = a;
            y = b;
        end
        exu  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        ex   = $signed({4'd0, exu});
        d    = exu - ey;
        xw   = {1'b0, x[30:23] != 8'd0, x[22:0], 24'd0};
        yw   = {1'b0, y[30:23] != 8'd0, y[22:0], 24'd0};
        mask = 49'd0;
        if (d >= 8'd49) begin
            ys   = 49'd0;
            lost = |yw;
        end
        else begin
            ys   = yw >> d;
            mask = (49'd1 << d) - 49'd1;
            lost = |(yw & mask);
        end
        ys[0] = ys[0] | lost;
        r     = (x[31] == y[31]) ? (xw + ys) : (xw - ys);
        lz    = lzc49(r);
        be    = ex + 12'sd1 - $signed({6'd0, lz});
        priority if (a_nan) begin
            res = a | QUIET_BIT;
        end
        else if (b_nan) begin
            res = b | QUIET_BIT;
        end
        else if (a_inf && b_inf && (a[31] != b[31])) begin
            res = DEFAULT_NAN;
        end
        else if (a_inf) begin
            res = a;
        end
        else if (b_inf) begin
            res = b;
        end
        else if (r == 49'd0) begin
            res = {a[31] & b[31], 31'd0};
        end
        else begin
            res = round_pack(x[31], be, r << lz);
        end
        return res;
    endfunction

endpackage

[rtl/bone_world_matrix_chain.sv]
// Top level of the bone world matrix chain: input side, job queue and matrix engine.
//
//  Channel  | Dir | Beat contents
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | one matrix row of a bone: rest row and pose basis row
//  m_axis   | out | one world matrix row; tlast on row 3
//
// Rows 0 to 2 of a bone are taken in one cycle each while a job slot is free. Row 3 queues a job;
// the engine runs one float multiply and one float add per term, registering the product before the
// add, and makes one pass over the terms for a root bone and two with a parent, then four output beats.
// Reset clears the control state only; the world store holds no data until written.
// The input stalls only when both job slots are full; output stalls hold the engine.
module bone_world_matrix_chain
    import bwmc_pkg::*;
#(
    parameter int MAX_BONES = MAX_BONES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // bone_index, row_index, parent_index, bone_row_lo, bone_row_hi,
    // basis_row_lo, basis_row_hi, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // result_bone, result_row, world_row_lo, world_row_hi, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic head_valid;
    logic pop;
    job_t head_job;

    bwmc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    bwmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    bwmc_back #(
        .MAX_BONES (MAX_BONES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[rtl/bwmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bwmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/bwmc_front.sv]
// Input side: latches rest and basis rows and forms one job per bone on its last row.
module bwmc_front
    import bwmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    output logic                 push_valid,
    input  logic                 push_ready,
    output job_t                 push_job
);

    logic [7:0]       bone_index;
    logic [1:0]       row_index;
    logic [8:0]       parent_index;
    logic [ROW_W-1:0] rest_row;
    logic [ROW_W-1:0] basis_row;
    logic             accept;

    logic [ROW_W-1:0] rest_reg  [4];
    logic [ROW_W-1:0] basis_reg [4];
    logic [ROW_W-1:0] rest_next [4];
    logic [ROW_W-1:0] basis_next[4];

    assign bone_index   = s_axis_tdata[7:0];
    assign row_index    = s_axis_tdata[9:8];
    assign parent_index = s_axis_tdata[18:10];
    assign rest_row     = s_axis_tdata[146:19];
    assign basis_row    = s_axis_tdata[274:147];

    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && push_ready;
    assign push_valid    = s_axis_tvalid && (row_index == ROW_LAST);

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            rest_next[r]  = rest_reg[r];
            basis_next[r] = basis_reg[r];
        end
        if (accept)
        begin
            rest_next[row_index]  = rest_row;
            basis_next[row_index] = basis_row;
        end
        push_job.bone   = bone_index;
        push_job.parent = parent_index;
        for (int r = 0; r < 4; r++)
        begin
            push_job.rest[r*ROW_W +: ROW_W]  = rest_next[r];
            push_job.basis[r*ROW_W +: ROW_W] = basis_next[r];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            rest_reg[r]  <= rest_next[r];
            basis_reg[r] <= basis_next[r];
        end
    end

endmodule

[rtl/bwmc_queue.sv]
// Two-entry job queue between the input side and the matrix engine.
module bwmc_queue
    import bwmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic head_valid,
    input  logic pop,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/bwmc_back.sv]
// Matrix engine: one shared float multiplier and adder, world store, and row output.
module bwmc_back
    import bwmc_pkg::*;
#(
    parameter int MAX_BONES = MAX_BONES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  job_t                  head_job,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int ADDR_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       i_reg, i_next;
    logic [1:0]       k_reg, k_next;
    logic [1:0]       j_reg, j_next;
    logic             ph_reg, ph_next;
    logic             pass_reg, pass_next;
    logic [1:0]       row_reg, row_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      acc_reg, acc_next;
    logic [MAT_W-1:0] local_reg, local_next;
    logic [MAT_W-1:0] world_reg, world_next;

    logic [12:0]       bone_wide;
    logic [12:0]       parent_wide;
    logic              bone_ok;
    logic              parent_ok;
    logic [ADDR_W-1:0] bone_addr;
    logic [ADDR_W-1:0] parent_addr;
    logic              rd_en;
    logic              wr_en;
    logic [MAT_W-1:0]  parent_world;
    logic [MAT_W-1:0]  a_mat;
    logic [MAT_W-1:0]  b_mat;
    logic [31:0]       a_el;
    logic [31:0]       b_el;
    logic [31:0]       mul_res;
    logic [31:0]       add_res;
    logic [ROW_W-1:0]  world_row;

    assign bone_wide   = {5'd0, head_job.bone};
    assign parent_wide = {5'd0, head_job.parent[7:0]};
    assign bone_ok     = bone_wide < 13'(MAX_BONES);
    assign parent_ok   = !head_job.parent[8] && (parent_wide < 13'(MAX_BONES));
    assign bone_addr   = bone_wide[ADDR_W-1:0];
    assign parent_addr = parent_wide[ADDR_W-1:0];

    bwmc_ram #(
        .WIDTH (MAT_W),
        .DEPTH (MAX_BONES)
    ) u_world_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (bone_addr),
        .wr_data (world_reg),
        .rd_en   (rd_en),
        .rd_addr (parent_addr),
        .rd_data (parent_world)
    );

    assign a_mat   = pass_reg ? parent_world : head_job.rest;
    assign b_mat   = pass_reg ? local_reg : head_job.basis;
    assign a_el    = a_mat[{i_reg, j_reg, 5'd0} +: 32];
    assign b_el    = b_mat[{j_reg, k_reg, 5'd0} +: 32];
    assign mul_res = fmul(a_el, b_el);
    assign add_res = fadd((j_reg == 2'd0) ? 32'd0 : acc_reg, prod_reg);

    assign world_row     = world_reg[{row_reg, 7'd0} +: ROW_W];
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tlast  = (row_reg == ROW_LAST);
    assign m_axis_tdata  = {6'd0, world_row, row_reg, head_job.bone};

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        ph_next    = ph_reg;
        pass_next  = pass_reg;
        row_next   = row_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        local_next = local_reg;
        world_next = world_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    rd_en      = 1'b1;
                    i_next     = 2'd0;
                    k_next     = 2'd0;
                    j_next     = 2'd0;
                    ph_next    = 1'b0;
                    pass_next  = 1'b0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!ph_reg)
                begin
                    prod_next = mul_res;
                    ph_next   = 1'b1;
                end
                else
                begin
                    ph_next  = 1'b0;
                    acc_next = add_res;
                    j_next   = j_reg + 2'd1;
                    if (j_reg == 2'd3)
                    begin
                        world_next[{i_reg, k_reg, 5'd0} +: 32] = add_res;
                        if (!pass_reg)
                        begin
                            local_next[{i_reg, k_reg, 5'd0} +: 32] = add_res;
                        end
                        k_next = k_reg + 2'd1;
                        if (k_reg == 2'd3)
                        begin
                            i_next = i_reg + 2'd1;
                            if (i_reg == 2'd3)
                            begin
                                if (!pass_reg && parent_ok)
                                begin
                                    pass_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_WR;
                                end
                            end
                        end
                    end
                end
            end
            ST_WR:
            begin
                wr_en      = bone_ok;
                row_next   = 2'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (m_axis_tready)
                begin
                    row_next = row_reg + 2'd1;
                    if (row_reg == ROW_LAST)
                    begin
                        pop        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        local_reg <= local_next;
        world_reg <= world_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= 2'd0;
            k_reg     <= 2'd0;
            j_reg     <= 2'd0;
            ph_reg    <= 1'b0;
            pass_reg  <= 1'b0;
            row_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            ph_reg    <= ph_next;
            pass_reg  <= pass_next;
            row_reg   <= row_next;
        end
    end

endmodule
